// ----- rtl/rx_escape_filter_ring_core_macros.svh -----
// Assertion helpers for the checker file.
`ifndef RX_ESCAPE_FILTER_RING_CORE_MACROS_SVH
`define RX_ESCAPE_FILTER_RING_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RXEF_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RXEF_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rxef_pkg.sv -----
package rxef_pkg;

  // Input transaction.
  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0]  popped_byte;
    logic        pop_valid;
    logic [15:0] window_rows;
    logic [15:0] window_cols;
    logic        ring_not_empty;
  } out_item_t;

  // Operation codes.
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Characters of the size sequence.
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Reset values.
  localparam logic [15:0] MIN_ROWS_RST = 16'd8;
  localparam logic [15:0] MIN_COLS_RST = 16'd40;
  localparam logic [15:0] ROWS_RST     = 16'd38;
  localparam logic [15:0] COLS_RST     = 16'd96;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_ROWS = 2'd0,
    REG_MIN_COLS = 2'd1
  } cfg_reg_t;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_POP,
    CLS_ESC,
    CLS_RBR,
    CLS_SEVEN,
    CLS_SEMI,
    CLS_DIGIT,
    CLS_BEL,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
  } cmd_t;

  // Front-to-back queue head.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fe_be_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Parser phases.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_BRACKET = 3'd2,
    PH_SEVEN1  = 3'd3,
    PH_SEVEN2  = 3'd4,
    PH_SEVEN3  = 3'd5,
    PH_ROWS    = 3'd6,
    PH_COLS    = 3'd7
  } phase_t;

  // Back-end sequencer.
  typedef enum logic [1:0] {
    B_IDLE,
    B_SPILL,
    B_RESULT
  } bst_t;

endpackage

// ----- rtl/rxef_front.sv -----
module rxef_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rxef_pkg::in_item_t in_data,
  output rxef_pkg::fe_be_t   q,
  input  logic               q_pop
);

  rxef_pkg::cmd_t                    entries [rxef_pkg::QUEUE_DEPTH];
  logic [rxef_pkg::QUEUE_AW-1:0]     wr_ptr;
  logic [rxef_pkg::QUEUE_AW-1:0]     rd_ptr;
  logic [rxef_pkg::QUEUE_CW-1:0]     count;
  rxef_pkg::cmd_t                    cmd_in;
  logic                              push;
  logic                              pop;

  // Classify the incoming transaction.
  always_comb begin
    cmd_in.data = in_data.rx_byte;
    if (in_data.op == rxef_pkg::OP_POP) begin
      cmd_in.cls = rxef_pkg::CLS_POP;
    end else begin
      case (in_data.rx_byte) inside
        rxef_pkg::CH_ESC:                       cmd_in.cls = rxef_pkg::CLS_ESC;
        rxef_pkg::CH_RBR:                       cmd_in.cls = rxef_pkg::CLS_RBR;
        rxef_pkg::CH_SEVEN:                     cmd_in.cls = rxef_pkg::CLS_SEVEN;
        rxef_pkg::CH_SEMI:                      cmd_in.cls = rxef_pkg::CLS_SEMI;
        rxef_pkg::CH_BEL:                       cmd_in.cls = rxef_pkg::CLS_BEL;
        [rxef_pkg::CH_ZERO:rxef_pkg::CH_NINE]:  cmd_in.cls = rxef_pkg::CLS_DIGIT;
        default:                                cmd_in.cls = rxef_pkg::CLS_OTHER;
      endcase
    end
  end

  function automatic logic [rxef_pkg::QUEUE_AW-1:0] q_inc(
    input logic [rxef_pkg::QUEUE_AW-1:0] p
  );
    q_inc = (p == rxef_pkg::QUEUE_AW'(rxef_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall = (count == rxef_pkg::QUEUE_CW'(rxef_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != '0);

  assign q.valid = (count != '0);
  assign q.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= q_inc(wr_ptr);
      if (pop)  rd_ptr <= q_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/rxef_back.sv -----
module rxef_back #(
  parameter int RING_DEPTH    = 256,
  parameter int PENDING_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [rxef_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rxef_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rxef_pkg::fe_be_t                    q,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rxef_pkg::out_item_t                 out_data
);

  localparam int RAW = $clog2(RING_DEPTH);
  localparam int PAW = $clog2(PENDING_DEPTH);
  localparam int PCW = $clog2(PENDING_DEPTH + 1);

  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] pend_mem [PENDING_DEPTH];

  rxef_pkg::bst_t   state, state_next;
  rxef_pkg::phase_t phase, phase_next;
  logic [RAW-1:0]   head, head_next;
  logic [RAW-1:0]   tail, tail_next;
  logic [PCW-1:0]   pend_count, pend_count_next;
  logic [PCW-1:0]   spill_idx, spill_idx_next;
  logic             spill_rd_valid, spill_rd_valid_next;
  logic [15:0]      rows_accum, rows_accum_next;
  logic [15:0]      cols_accum, cols_accum_next;
  logic [15:0]      rows_cur, rows_cur_next;
  logic [15:0]      cols_cur, cols_cur_next;
  logic [15:0]      min_rows;
  logic [15:0]      min_cols;
  logic             pop_flag, pop_flag_next;
  logic [7:0]       ring_rd_data;
  logic [7:0]       pend_rd_data;

  logic             start;
  logic             ring_full;
  logic             ring_empty;
  logic             ring_rd_en;
  logic             put_en;
  logic [7:0]       put_data;
  logic             keep_en;
  logic             pend_rd_en;
  logic             spill_go;
  logic             spill_done;
  logic             load_out;
  rxef_pkg::cmd_t   cmd;

  function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] p);
    ring_inc = (p == RAW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cmd        = q.cmd;
  assign start      = (state == rxef_pkg::B_IDLE) && q.valid;
  assign q_pop      = start;
  assign ring_full  = (ring_inc(head) == tail);
  assign ring_empty = (head == tail);
  assign pend_rd_en = (state == rxef_pkg::B_SPILL) && (spill_idx < pend_count);
  assign spill_done = (state == rxef_pkg::B_SPILL) && !pend_rd_en && !spill_rd_valid;
  assign load_out   = (state == rxef_pkg::B_RESULT) && (!out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rxef_pkg::B_IDLE: begin
        if (start) state_next = spill_go ? rxef_pkg::B_SPILL : rxef_pkg::B_RESULT;
      end
      rxef_pkg::B_SPILL: begin
        if (spill_done) state_next = rxef_pkg::B_RESULT;
      end
      rxef_pkg::B_RESULT: begin
        if (load_out) state_next = rxef_pkg::B_IDLE;
      end
      default: state_next = rxef_pkg::B_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    phase_next          = phase;
    head_next           = head;
    tail_next           = tail;
    pend_count_next     = pend_count;
    spill_idx_next      = spill_idx;
    spill_rd_valid_next = 1'b0;
    rows_accum_next     = rows_accum;
    cols_accum_next     = cols_accum;
    rows_cur_next       = rows_cur;
    cols_cur_next       = cols_cur;
    pop_flag_next       = pop_flag;
    ring_rd_en          = 1'b0;
    put_en              = 1'b0;
    put_data            = cmd.data;
    keep_en             = 1'b0;
    spill_go            = 1'b0;

    case (state)
      rxef_pkg::B_IDLE: begin
        if (start) begin
          pop_flag_next = 1'b0;
          if (cmd.cls == rxef_pkg::CLS_POP) begin
            if (!ring_empty) begin
              ring_rd_en    = 1'b1;
              tail_next     = ring_inc(tail);
              pop_flag_next = 1'b1;
            end
          end else if (phase == rxef_pkg::PH_IDLE) begin
            if (cmd.cls == rxef_pkg::CLS_ESC) begin
              keep_en    = 1'b1;
              phase_next = rxef_pkg::PH_ESC;
            end else begin
              put_en = 1'b1;
            end
          end else begin
            keep_en = 1'b1;
            case (phase)
              rxef_pkg::PH_ESC: begin
                if (cmd.cls == rxef_pkg::CLS_RBR) phase_next = rxef_pkg::PH_BRACKET;
                else spill_go = 1'b1;
              end
              rxef_pkg::PH_BRACKET: begin
                if (cmd.cls == rxef_pkg::CLS_SEVEN) phase_next = rxef_pkg::PH_SEVEN1;
                else spill_go = 1'b1;
              end
              rxef_pkg::PH_SEVEN1: begin
                if (cmd.cls == rxef_pkg::CLS_SEVEN) phase_next = rxef_pkg::PH_SEVEN2;
                else spill_go = 1'b1;
              end
              rxef_pkg::PH_SEVEN2: begin
                if (cmd.cls == rxef_pkg::CLS_SEVEN) phase_next = rxef_pkg::PH_SEVEN3;
                else spill_go = 1'b1;
              end
              rxef_pkg::PH_SEVEN3: begin
                if (cmd.cls == rxef_pkg::CLS_SEMI) phase_next = rxef_pkg::PH_ROWS;
                else spill_go = 1'b1;
              end
              rxef_pkg::PH_ROWS: begin
                // the digit 7 arrives classified as CLS_SEVEN
                if (cmd.cls inside {rxef_pkg::CLS_DIGIT, rxef_pkg::CLS_SEVEN}) begin
                  // accum * 10 + digit, wrapping at 16 bits
                  rows_accum_next = (rows_accum << 3) + (rows_accum << 1)
                                  + {12'd0, cmd.data[3:0]};
                end else if (cmd.cls == rxef_pkg::CLS_SEMI) begin
                  phase_next = rxef_pkg::PH_COLS;
                end else begin
                  spill_go = 1'b1;
                end
              end
              rxef_pkg::PH_COLS: begin
                if (cmd.cls inside {rxef_pkg::CLS_DIGIT, rxef_pkg::CLS_SEVEN}) begin
                  cols_accum_next = (cols_accum << 3) + (cols_accum << 1)
                                  + {12'd0, cmd.data[3:0]};
                end else if (cmd.cls == rxef_pkg::CLS_BEL) begin
                  if (rows_accum >= min_rows && cols_accum >= min_cols) begin
                    rows_cur_next = rows_accum;
                    cols_cur_next = cols_accum;
                  end
                  pend_count_next = '0;
                  phase_next      = rxef_pkg::PH_IDLE;
                  rows_accum_next = '0;
                  cols_accum_next = '0;
                  keep_en         = 1'b0;
                end else begin
                  spill_go = 1'b1;
                end
              end
              default: spill_go = 1'b1;
            endcase
          end
          if (keep_en && pend_count < PCW'(PENDING_DEPTH)) begin
            pend_count_next = pend_count + 1'b1;
          end
          if (spill_go) spill_idx_next = '0;
        end
      end

      rxef_pkg::B_SPILL: begin
        if (pend_rd_en) spill_idx_next = spill_idx + 1'b1;
        spill_rd_valid_next = pend_rd_en;
        if (spill_rd_valid) begin
          put_en   = 1'b1;
          put_data = pend_rd_data;
        end
        if (spill_done) begin
          pend_count_next = '0;
          phase_next      = rxef_pkg::PH_IDLE;
          rows_accum_next = '0;
          cols_accum_next = '0;
        end
      end

      default: ;
    endcase

    // Full ring drops the byte.
    if (put_en && !ring_full) head_next = ring_inc(head);
  end

  // Ring storage.
  always_ff @(posedge clk) begin
    if (put_en && !ring_full) ring_mem[head] <= put_data;
    if (ring_rd_en) ring_rd_data <= ring_mem[tail];
  end

  // Pending storage.
  always_ff @(posedge clk) begin
    if (keep_en && pend_count < PCW'(PENDING_DEPTH)) begin
      pend_mem[pend_count[PAW-1:0]] <= cmd.data;
    end
    if (pend_rd_en) pend_rd_data <= pend_mem[spill_idx[PAW-1:0]];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.popped_byte    <= pop_flag ? ring_rd_data : 8'd0;
      out_data.pop_valid      <= pop_flag;
      out_data.window_rows    <= rows_cur;
      out_data.window_cols    <= cols_cur;
      out_data.ring_not_empty <= !ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rxef_pkg::B_IDLE;
      phase          <= rxef_pkg::PH_IDLE;
      head           <= '0;
      tail           <= '0;
      pend_count     <= '0;
      spill_idx      <= '0;
      spill_rd_valid <= 1'b0;
      rows_accum     <= '0;
      cols_accum     <= '0;
      rows_cur       <= rxef_pkg::ROWS_RST;
      cols_cur       <= rxef_pkg::COLS_RST;
      min_rows       <= rxef_pkg::MIN_ROWS_RST;
      min_cols       <= rxef_pkg::MIN_COLS_RST;
      pop_flag       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      phase          <= phase_next;
      head           <= head_next;
      tail           <= tail_next;
      pend_count     <= pend_count_next;
      spill_idx      <= spill_idx_next;
      spill_rd_valid <= spill_rd_valid_next;
      rows_accum     <= rows_accum_next;
      cols_accum     <= cols_accum_next;
      rows_cur       <= rows_cur_next;
      cols_cur       <= cols_cur_next;
      pop_flag       <= pop_flag_next;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_wen) begin
        case (cfg_index)
          rxef_pkg::REG_MIN_ROWS: min_rows <= cfg_data;
          rxef_pkg::REG_MIN_COLS: min_cols <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/rx_escape_filter_ring_core.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | rxef_pkg::in_item_t  (op, rx_byte)
// out     | output    | out_valid/out_stall| rxef_pkg::out_item_t (one per input)
// cfg     | input     | cfg_wen            | cfg_index, cfg_data (min_rows, min_cols)
//
// Plain bytes and pops are executed in B_IDLE, then B_RESULT loads the
// result register. A byte that breaks a size sequence flushes the N pending
// bytes (N <= PENDING_DEPTH) one per cycle via the pending read port.
// Reset is synchronous on rst; it clears control state, the ring and parser.
// The input stalls only when the front queue is full; the result register
// holds while out_stall is high and the back end waits for it.
module rx_escape_filter_ring_core #(
  parameter int RING_DEPTH    = 256,  // ring holds RING_DEPTH-1 bytes
  parameter int PENDING_DEPTH = 32    // bytes remembered while parsing
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rxef_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rxef_pkg::out_item_t              out_data,
  input  logic                             cfg_wen,
  input  logic [rxef_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rxef_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Classified transactions waiting for the back end.
  rxef_pkg::fe_be_t q;
  logic             q_pop;

  // Front end: byte classification plus a short queue.
  rxef_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q        (q),
    .q_pop    (q_pop)
  );

  // Back end: parser, pending buffer, ring and result register.
  rxef_back #(
    .RING_DEPTH    (RING_DEPTH),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q         (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/rxef_checker.sv -----
`include "rx_escape_filter_ring_core_macros.svh"

module rxef_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rxef_pkg::out_item_t out_data
);

  `RXEF_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `RXEF_CHECK_NOW(a_pop_zero, out_valid && !out_data.pop_valid, out_data.popped_byte == 8'd0, "popped byte without a pop")
  `RXEF_CHECK_NOW(a_rst_out, $past(rst), !out_valid, "result present right after reset")
  `RXEF_CHECK_NOW(a_rst_in, $past(rst), !in_stall, "input stalled right after reset")

endmodule

bind rx_escape_filter_ring_core rxef_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/tb_rx_escape_filter_ring_core.sv -----
`timescale 1ns / 1ps

module tb_rx_escape_filter_ring_core;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  rxef_pkg::in_item_t   in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  rxef_pkg::out_item_t  out_data;
  logic                 cfg_wen   = 1'b0;
  logic [rxef_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rxef_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  rx_escape_filter_ring_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------
  // Predictor state: ring, pending sequence bytes, parser, window size.
  // Ring pointers are 8 bits so they wrap at the 256-entry depth.
  // ---------------------------------------------------------------
  logic [7:0]        ring_mem [256];
  logic [7:0]        ring_wr = '0;
  logic [7:0]        ring_rd = '0;
  logic [7:0]        hold_mem [32];
  int                hold_cnt = 0;
  rxef_pkg::phase_t  ph = rxef_pkg::PH_IDLE;
  logic [15:0]       acc_rows = '0;
  logic [15:0]       acc_cols = '0;
  logic [15:0]       win_rows = rxef_pkg::ROWS_RST;
  logic [15:0]       win_cols = rxef_pkg::COLS_RST;
  logic [15:0]       lim_rows = rxef_pkg::MIN_ROWS_RST;
  logic [15:0]       lim_cols = rxef_pkg::MIN_COLS_RST;

  rxef_pkg::out_item_t result_q [$];   // predicted results, oldest first
  rxef_pkg::out_item_t want_r;
  int          n_errors  = 0;
  int          n_results = 0;
  int          n_sent    = 0;

  // Sender burst shaping and receiver stall pattern.
  int          burst_left = 0;
  int          pop_pct    = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          run_left   = 0;

  logic [7:0]  seq_buf [$];    // bytes of the transaction group being built

  // Full ring drops the byte; ring holds at most 255.
  function automatic void ring_push(logic [7:0] b);
    if (8'(ring_wr + 8'd1) != ring_rd) begin
      ring_mem[ring_wr] = b;
      ring_wr = ring_wr + 8'd1;
    end
  endfunction

  function automatic void parser_clear();
    hold_cnt = 0;
    ph       = rxef_pkg::PH_IDLE;
    acc_rows = '0;
    acc_cols = '0;
  endfunction

  // Past 32 bytes the parser keeps going but stops remembering.
  function automatic void hold_byte(logic [7:0] b);
    if (hold_cnt < 32) begin
      hold_mem[hold_cnt] = b;
      hold_cnt++;
    end
  endfunction

  function automatic void spill_held();
    for (int i = 0; i < hold_cnt; i++) ring_push(hold_mem[i]);
    parser_clear();
  endfunction

  function automatic void filter_byte(logic [7:0] b);
    logic dig;
    dig = (b >= rxef_pkg::CH_ZERO) && (b <= rxef_pkg::CH_NINE);
    if (ph == rxef_pkg::PH_IDLE) begin
      if (b == rxef_pkg::CH_ESC) begin
        hold_byte(b);
        ph = rxef_pkg::PH_ESC;
      end else begin
        ring_push(b);
      end
      return;
    end
    hold_byte(b);
    case (ph)
      rxef_pkg::PH_ESC: begin
        if (b == rxef_pkg::CH_RBR) ph = rxef_pkg::PH_BRACKET;
        else spill_held();
      end
      rxef_pkg::PH_BRACKET, rxef_pkg::PH_SEVEN1, rxef_pkg::PH_SEVEN2: begin
        if (b == rxef_pkg::CH_SEVEN) ph = rxef_pkg::phase_t'(ph + 3'd1);
        else spill_held();
      end
      rxef_pkg::PH_SEVEN3: begin
        if (b == rxef_pkg::CH_SEMI) ph = rxef_pkg::PH_ROWS;
        else spill_held();
      end
      rxef_pkg::PH_ROWS: begin
        if (dig) acc_rows = acc_rows * 16'd10 + {8'd0, 8'(b - rxef_pkg::CH_ZERO)};
        else if (b == rxef_pkg::CH_SEMI) ph = rxef_pkg::PH_COLS;
        else spill_held();
      end
      rxef_pkg::PH_COLS: begin
        if (dig) begin
          acc_cols = acc_cols * 16'd10 + {8'd0, 8'(b - rxef_pkg::CH_ZERO)};
        end else if (b == rxef_pkg::CH_BEL) begin
          // complete sequence: size taken only at or above the limits
          if (acc_rows >= lim_rows && acc_cols >= lim_cols) begin
            win_rows = acc_rows;
            win_cols = acc_cols;
          end
          parser_clear();
        end else begin
          spill_held();
        end
      end
      default: spill_held();
    endcase
  endfunction

  function automatic rxef_pkg::out_item_t predict_result(rxef_pkg::in_item_t t);
    rxef_pkg::out_item_t r;
    r = '0;
    if (t.op == rxef_pkg::OP_FILTER) begin
      filter_byte(t.rx_byte);
    end else if (ring_rd != ring_wr) begin
      r.popped_byte = ring_mem[ring_rd];
      r.pop_valid   = 1'b1;
      ring_rd       = ring_rd + 8'd1;
    end
    r.window_rows    = win_rows;
    r.window_cols    = win_cols;
    r.ring_not_empty = (ring_rd != ring_wr);
    return r;
  endfunction

  // One line per mismatch, and a count.
  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
  endtask

  // ---------------------------------------------------------------
  // Result side: check each accepted transaction, then pick the stall
  // for the next cycle. Values read here are the pre-edge ones.
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_data.popped_byte), 0);
      end else begin
        want_r = result_q.pop_front();
        if (out_data.popped_byte !== want_r.popped_byte)
          report_mismatch("popped_byte", int'(out_data.popped_byte),
                          int'(want_r.popped_byte));
        if (out_data.pop_valid !== want_r.pop_valid)
          report_mismatch("pop_valid", int'(out_data.pop_valid), int'(want_r.pop_valid));
        if (out_data.window_rows !== want_r.window_rows)
          report_mismatch("window_rows", int'(out_data.window_rows),
                          int'(want_r.window_rows));
        if (out_data.window_cols !== want_r.window_cols)
          report_mismatch("window_cols", int'(out_data.window_cols),
                          int'(want_r.window_cols));
        if (out_data.ring_not_empty !== want_r.ring_not_empty)
          report_mismatch("ring_not_empty", int'(out_data.ring_not_empty),
                          int'(want_r.ring_not_empty));
      end
      n_results++;
    end
    // stall modes: open, light, heavy, and long runs
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left > 0) begin
          run_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 15) == 0) run_left = $urandom_range(5, 20);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Input side. Valid stays high across a burst; a gap between bursts
  // lowers it. The prediction is made on the accepting edge.
  // ---------------------------------------------------------------
  task automatic send_item(logic op, logic [7:0] b);
    rxef_pkg::in_item_t t;
    int                 gap;
    t.op      = op;
    t.rx_byte = b;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 250);
      else burst_left = $urandom_range(1, 30);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    result_q.push_back(predict_result(t));
    n_sent++;
  endtask

  // Filter the bytes in seq_buf, with pops mixed in at pop_pct.
  task automatic send_seq();
    foreach (seq_buf[i]) begin
      if ($urandom_range(0, 99) < pop_pct) send_item(rxef_pkg::OP_POP, 8'($urandom));
      send_item(rxef_pkg::OP_FILTER, seq_buf[i]);
    end
  endtask

  // Stop sending and let every predicted result drain.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both limits, then a write to an unused index that must be ignored.
  task automatic set_limits(logic [15:0] rows, logic [15:0] cols);
    cfg_wen   <= 1'b1;
    cfg_index <= rxef_pkg::REG_MIN_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= rxef_pkg::REG_MIN_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= 2'($urandom_range(2, 3));
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    lim_rows = rows;
    lim_cols = cols;
  endtask

  // Decimal field: near the limit, anywhere, zero-padded, very long
  // (wraps and overruns the pending store) or empty.
  task automatic append_number(logic [15:0] floor);
    int    v;
    int    style;
    string s;
    style = $urandom_range(0, 9);
    s = "";
    if (style <= 4) begin
      v = int'(floor) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      s = $sformatf("%0d", v);
    end else if (style <= 6) begin
      s = $sformatf("%0d", $urandom_range(0, 65535));
    end else if (style == 7) begin
      s = {"00", $sformatf("%0d", floor)};
    end else if (style == 8) begin
      repeat ($urandom_range(6, 40))
        seq_buf.push_back(8'(rxef_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    for (int i = 0; i < s.len(); i++) seq_buf.push_back(s[i]);
  endtask

  task automatic build_size_seq();
    seq_buf = {rxef_pkg::CH_ESC, rxef_pkg::CH_RBR, rxef_pkg::CH_SEVEN,
               rxef_pkg::CH_SEVEN, rxef_pkg::CH_SEVEN, rxef_pkg::CH_SEMI};
    append_number(lim_rows);
    seq_buf.push_back(rxef_pkg::CH_SEMI);
    append_number(lim_cols);
    seq_buf.push_back(rxef_pkg::CH_BEL);
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------

  // Pop on an empty ring, extreme bytes through the ring, reset size.
  task automatic test_empty_and_plain();
    pop_pct = 0;
    send_item(rxef_pkg::OP_POP, 8'hff);
    send_item(rxef_pkg::OP_FILTER, 8'h00);
    send_item(rxef_pkg::OP_FILTER, 8'hff);
    send_item(rxef_pkg::OP_POP, 8'h00);
    send_item(rxef_pkg::OP_POP, 8'hff);
    send_item(rxef_pkg::OP_POP, 8'h00);
  endtask

  // A well-formed size sequence is absorbed and updates the size.
  task automatic test_size_update();
    pop_pct = 0;
    seq_buf = {rxef_pkg::CH_ESC, rxef_pkg::CH_RBR, rxef_pkg::CH_SEVEN,
               rxef_pkg::CH_SEVEN, rxef_pkg::CH_SEVEN, rxef_pkg::CH_SEMI, 8'h39,
               rxef_pkg::CH_SEMI, 8'h34, 8'h31, rxef_pkg::CH_BEL};
    send_seq();
  endtask

  // A broken sequence lands in the ring in order, offending byte last.
  task automatic test_sequence_break();
    pop_pct = 0;
    seq_buf = {rxef_pkg::CH_ESC, rxef_pkg::CH_RBR, rxef_pkg::CH_SEVEN, 8'h21};
    send_seq();
    repeat (4) send_item(rxef_pkg::OP_POP, 8'($urandom));
  endtask

  // Overfill the ring so bytes drop, then drain past empty.
  task automatic test_ring_full();
    pop_pct = 0;
    seq_buf.delete();
    repeat (300) seq_buf.push_back(8'($urandom));
    send_seq();
    repeat (260) send_item(rxef_pkg::OP_POP, 8'($urandom));
  endtask

  // Half size sequences with random content, some broken; half noise.
  task automatic test_random_traffic(int n, int pops);
    int stop;
    int kind;
    int k;
    stop    = n_sent + n;
    pop_pct = pops;
    while (n_sent < stop) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        build_size_seq();
        if (kind >= 3) begin
          k = $urandom_range(1, seq_buf.size() - 1);
          case ($urandom_range(0, 4))
            0: seq_buf[k] = rxef_pkg::CH_ESC;
            1: seq_buf[k] = rxef_pkg::CH_BEL;
            2: seq_buf[k] = rxef_pkg::CH_SEMI;
            3: seq_buf[k] = 8'(rxef_pkg::CH_ZERO + $urandom_range(0, 9));
            default: seq_buf[k] = 8'($urandom);
          endcase
          while (seq_buf.size() > k + 1) void'(seq_buf.pop_back());
        end
      end else begin
        seq_buf.delete();
        if ($urandom_range(0, 3) == 0) seq_buf.push_back(rxef_pkg::CH_ESC);
        repeat ($urandom_range(1, 6)) seq_buf.push_back(8'($urandom));
      end
      send_seq();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_plain();
    test_size_update();
    test_sequence_break();
    test_ring_full();
    test_random_traffic(400, 35);

    wait_idle();
    set_limits(16'd0, 16'd0);
    test_random_traffic(350, 30);

    wait_idle();
    set_limits(16'hffff, 16'hffff);
    test_random_traffic(250, 30);

    wait_idle();
    set_limits(16'($urandom_range(0, 100)), 16'($urandom_range(0, 300)));
    test_random_traffic(150, 25);

    wait_idle();
    set_limits(16'($urandom), 16'($urandom));
    test_random_traffic(150, 40);

    wait_idle();
    repeat (40) @(posedge clk);
    if (result_q.size() != 0) report_mismatch("results never came", result_q.size(), 0);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
